### src/s5r_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and text helpers for the SOCKS5 UDP header reframer.
// No dependencies; s5r_text_gen and the top level in src use it by scoped names.
package s5r_pkg;

  // Status codes carried with each result item
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_SOURCE   = 3'd1;
  localparam logic [2:0] ST_RESERVED = 3'd2;
  localparam logic [2:0] ST_FRAGMENT = 3'd3;
  localparam logic [2:0] ST_ADDRTYPE = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_LIMIT_ENABLE  = 2'd0;
  localparam logic [1:0] REG_LIMIT_ADDRESS = 2'd1;
  localparam logic [1:0] REG_LIMIT_PORT    = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPA   = 8'h41;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [5:0] V6_TEXT_LEN = 6'd39;

  // Text generator toward the output stage
  typedef struct packed {
    logic       valid;
    logic       busy;
    logic [7:0] data;
  } txt_t;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_t;

  function automatic dec_t dec_split(input logic [7:0] v);
    dec_t       d;
    logic [6:0] r;
    logic [14:0] p;
    if (v >= 8'd200) begin
      d.hund = 2'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      d.hund = 2'd1;
      r = 7'(v - 8'd100);
    end else begin
      d.hund = 2'd0;
      r = v[6:0];
    end
    // r / 10 for r below 100 as multiply by 205 and shift by 11
    p = {8'b0, r} * 15'd205;
    d.tens = p[14:11];
    d.ones = 4'(r - 7'(d.tens) * 7'd10);
    return d;
  endfunction

  function automatic logic [1:0] dec_count(input logic [7:0] v);
    logic [1:0] c;
    if (v >= 8'd100) c = 2'd3;
    else if (v >= 8'd10) c = 2'd2;
    else c = 2'd1;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = CHAR_ZERO + {4'b0, n};
    else c = CHAR_UPA + {4'b0, n} - 8'd10;
    return c;
  endfunction

endpackage

### src/s5r_addr_mem.sv
`timescale 1ns / 1ps
// Address byte store: 16 x 8 memory, one write and one registered read port.
// Depends on nothing.
module s5r_addr_mem (
  input  logic       clk,
  input  logic       we,
  input  logic [3:0] waddr,
  input  logic [7:0] wdata,
  input  logic [3:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/s5r_text_gen.sv
`timescale 1ns / 1ps
// Address text sequencer: reads the address store and emits the host length
// byte and dotted decimal or hex group text. Depends on s5r_pkg.
module s5r_text_gen (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           is_v6,
  input  logic           take,
  output logic [3:0]     raddr,
  input  logic [7:0]     rdata,
  output s5r_pkg::txt_t  txt
);

  typedef enum logic [2:0] {T_IDLE, T_SUM, T_LEN, T_FETCH, T_DIG} tstate_t;

  tstate_t      state;
  logic         v6;
  logic [2:0]   cnt;
  logic [3:0]   idx;
  logic [1:0]   pos;
  logic [5:0]   len;
  logic [3:0]   en;
  logic [7:0]   ch;
  s5r_pkg::dec_t dd;

  assign raddr = (state == T_SUM) ? {2'b0, cnt[1:0]} : idx;
  assign dd = s5r_pkg::dec_split(rdata);

  always_comb begin
    en[0] = (idx != 4'd0) && (!v6 || !idx[0]);
    en[1] = v6 || (rdata >= 8'd100);
    en[2] = !v6 && (rdata >= 8'd10);
    en[3] = 1'b1;
    case (pos)
      2'd0:    ch = v6 ? s5r_pkg::CHAR_COLON : s5r_pkg::CHAR_DOT;
      2'd1:    ch = v6 ? s5r_pkg::hex_char(rdata[7:4])
                       : s5r_pkg::CHAR_ZERO + {6'b0, dd.hund};
      2'd2:    ch = s5r_pkg::CHAR_ZERO + {4'b0, dd.tens};
      default: ch = v6 ? s5r_pkg::hex_char(rdata[3:0])
                       : s5r_pkg::CHAR_ZERO + {4'b0, dd.ones};
    endcase
  end

  always_comb begin
    txt.busy  = (state != T_IDLE);
    txt.valid = 1'b0;
    txt.data  = ch;
    case (state)
      T_LEN: begin
        txt.valid = 1'b1;
        txt.data  = {2'b0, len};
      end
      T_DIG: begin
        txt.valid = en[pos];
      end
      default: begin
        txt.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      v6    <= 1'b0;
      cnt   <= 3'd0;
      idx   <= 4'd0;
      pos   <= 2'd0;
      len   <= 6'd0;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) begin
            v6    <= is_v6;
            cnt   <= 3'd0;
            idx   <= 4'd0;
            pos   <= 2'd0;
            len   <= is_v6 ? s5r_pkg::V6_TEXT_LEN : 6'd3;
            state <= is_v6 ? T_LEN : T_SUM;
          end
        end
        T_SUM: begin
          // read data is registered, so it trails the address
          if (cnt != 3'd0) begin
            len <= len + {4'b0, s5r_pkg::dec_count(rdata)};
          end
          if (cnt == 3'd4) begin
            state <= T_LEN;
          end
          cnt <= cnt + 3'd1;
        end
        T_LEN: begin
          if (take) begin
            state <= T_FETCH;
          end
        end
        T_FETCH: begin
          state <= T_DIG;
        end
        T_DIG: begin
          if (!en[pos]) begin
            pos <= pos + 2'd1;
          end else if (take) begin
            if (pos == 2'd3) begin
              pos <= 2'd0;
              if (idx == (v6 ? 4'd15 : 4'd3)) begin
                state <= T_IDLE;
              end else begin
                idx   <= idx + 4'd1;
                state <= T_FETCH;
              end
            end else begin
              pos <= pos + 2'd1;
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

### src/socks5_udp_header_reframer.sv
`timescale 1ns / 1ps
// SOCKS5 UDP header reframer top level: parser, result queue, output register.
// Depends on s5r_pkg, s5r_addr_mem and s5r_text_gen.
//
// Input items are datagram bytes on in_valid/in_ready, each carrying the
// packet length and source address and port. Result items leave on
// out_valid/out_ready: host length, host text, port, payload length,
// payload, or a single status item when a packet is dropped.
// A result appears in the output register the cycle after the item that
// causes it is accepted. Payload and most header bytes go through at one
// item per cycle while the receiver keeps up. An item with several results
// holds the input until they drain, one per cycle while the receiver is
// ready: four for the port/length bytes, two for a name byte that ends the
// packet. The last address byte starts the text sequencer: an IPv4 address
// takes a digit count pass, the length byte, then per address byte a fetch
// step and four digit positions; an IPv6 address takes the length byte,
// then per address byte a fetch step and four digit positions. The input
// opens again once the sequencer is idle. The single read port of the
// address store serializes these steps.
// Reset returns the parser to the header start, clears the filter registers
// and empties the output. A stalled receiver holds the output register and,
// through it, the input; no item is lost.
module socks5_udp_header_reframer (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [15:0] packet_length,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [2:0]  status
);

  typedef enum logic [2:0] {
    PH_HDR, PH_NAMELEN, PH_ADDR, PH_NAME, PH_PORTHI, PH_PORTLO, PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {K_NONE, K_V4, K_V6, K_NAME} kind_t;

  typedef enum logic [1:0] {S_IDLE, S_MULTI, S_TEXT} ostate_t;

  // configuration registers
  logic        limit_enable;
  logic [31:0] limit_address;
  logic [15:0] limit_port;

  // parser state
  logic [15:0] byte_index;
  phase_t      phase, phase_next;
  kind_t       kind, kind_next;
  logic [7:0]  name_length, name_length_next;
  logic [7:0]  port_high_byte, port_high_byte_next;
  logic        dropping;

  // output sequencing
  ostate_t     ostate;
  logic [7:0]  q_byte [3];
  logic [2:0]  q_stat [3];
  logic [1:0]  q_idx, q_cnt;

  // per-item results
  logic [7:0]  lb [4];
  logic [2:0]  ls [4];
  logic        l0_last;
  logic [2:0]  n;
  logic        drop;
  logic        last;
  logic [8:0]  hlen;
  logic [8:0]  v_hlen;
  logic [15:0] pay_len;
  logic        mem_we;
  logic        text_start;
  logic        accept;
  logic        out_free;
  logic        take;

  logic [3:0]  mem_raddr;
  logic [7:0]  mem_rdata;
  s5r_pkg::txt_t txt;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable  <= 1'b0;
      limit_address <= 32'd0;
      limit_port    <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        s5r_pkg::REG_LIMIT_ENABLE:  limit_enable  <= pwdata[0];
        s5r_pkg::REG_LIMIT_ADDRESS: limit_address <= pwdata;
        s5r_pkg::REG_LIMIT_PORT:    limit_port    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      s5r_pkg::REG_LIMIT_ENABLE:  prdata = {31'd0, limit_enable};
      s5r_pkg::REG_LIMIT_ADDRESS: prdata = limit_address;
      s5r_pkg::REG_LIMIT_PORT:    prdata = {16'd0, limit_port};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_free = !out_valid || out_ready;
  assign in_ready = (ostate == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign take     = (ostate == S_TEXT) && txt.valid && out_free;

  // ---------------- parser ----------------
  assign last = ({1'b0, byte_index} + 17'd1) >= {1'b0, packet_length};

  always_comb begin
    case (kind)
      K_V4:    hlen = 9'd10;
      K_V6:    hlen = 9'd22;
      default: hlen = 9'd7 + {1'b0, name_length};
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lb[i] = 8'd0;
      ls[i] = s5r_pkg::ST_DATA;
    end
    l0_last             = 1'b0;
    n                   = 3'd0;
    drop                = 1'b0;
    phase_next          = phase;
    kind_next           = kind;
    name_length_next    = name_length;
    port_high_byte_next = port_high_byte;
    mem_we              = 1'b0;
    text_start          = 1'b0;
    v_hlen              = 9'd10;
    pay_len             = packet_length - {7'd0, hlen};
    if (!dropping) begin
      case (phase)
        PH_HDR: begin
          if (byte_index == 16'd0) begin
            if (limit_enable && (source_address != limit_address ||
                                 source_port != limit_port)) begin
              drop = 1'b1;
              ls[n[1:0]] = s5r_pkg::ST_SOURCE;
              n = n + 3'd1;
            end else begin
              port_high_byte_next = data_byte;
            end
          end else if (byte_index == 16'd1) begin
            if ((port_high_byte | data_byte) != 8'd0) begin
              drop = 1'b1;
              ls[n[1:0]] = s5r_pkg::ST_RESERVED;
              n = n + 3'd1;
            end
          end else if (byte_index == 16'd2) begin
            if (data_byte != 8'd0) begin
              drop = 1'b1;
              ls[n[1:0]] = s5r_pkg::ST_FRAGMENT;
              n = n + 3'd1;
            end
          end else begin
            if (data_byte == 8'd1 || data_byte == 8'd4) begin
              kind_next = (data_byte == 8'd1) ? K_V4 : K_V6;
              v_hlen    = (data_byte == 8'd1) ? 9'd10 : 9'd22;
              if ({1'b0, packet_length} <= {8'd0, v_hlen}) begin
                drop = 1'b1;
                ls[n[1:0]] = s5r_pkg::ST_SHORT;
                n = n + 3'd1;
              end else begin
                phase_next = PH_ADDR;
              end
            end else if (data_byte == 8'd3) begin
              kind_next  = K_NAME;
              phase_next = PH_NAMELEN;
            end else begin
              drop = 1'b1;
              ls[n[1:0]] = s5r_pkg::ST_ADDRTYPE;
              n = n + 3'd1;
            end
          end
        end
        PH_NAMELEN: begin
          name_length_next = data_byte;
          if ({1'b0, packet_length} <= 17'd7 + {9'd0, data_byte}) begin
            drop = 1'b1;
            ls[n[1:0]] = s5r_pkg::ST_SHORT;
            n = n + 3'd1;
          end else begin
            lb[n[1:0]] = data_byte;
            n = n + 3'd1;
            phase_next = (data_byte != 8'd0) ? PH_NAME : PH_PORTHI;
          end
        end
        PH_NAME: begin
          lb[n[1:0]] = data_byte;
          n = n + 3'd1;
          if ({1'b0, byte_index} >= 17'd4 + {9'd0, name_length}) begin
            phase_next = PH_PORTHI;
          end
        end
        PH_ADDR: begin
          mem_we = 1'b1;
          if (last) begin
            drop = 1'b1;
            ls[n[1:0]] = s5r_pkg::ST_SHORT;
            n = n + 3'd1;
          end else if ((kind == K_V4 && byte_index >= 16'd7) ||
                       (kind == K_V6 && byte_index >= 16'd19)) begin
            text_start = 1'b1;
            phase_next = PH_PORTHI;
          end
        end
        PH_PORTHI: begin
          port_high_byte_next = data_byte;
          phase_next          = PH_PORTLO;
        end
        PH_PORTLO: begin
          if (last || ({1'b0, packet_length} <= {8'd0, hlen})) begin
            drop = 1'b1;
            ls[n[1:0]] = s5r_pkg::ST_SHORT;
            n = n + 3'd1;
          end else begin
            lb[0] = port_high_byte;
            lb[1] = data_byte;
            lb[2] = pay_len[15:8];
            lb[3] = pay_len[7:0];
            n = 3'd4;
            phase_next = PH_PAYLOAD;
          end
        end
        default: begin
          lb[0]   = data_byte;
          l0_last = last;
          n       = 3'd1;
        end
      endcase
      // packet ended before the payload began
      if (last && !drop && phase_next != PH_PAYLOAD) begin
        drop = 1'b1;
        ls[n[1:0]] = s5r_pkg::ST_SHORT;
        lb[n[1:0]] = 8'd0;
        n = n + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= 16'd0;
      phase          <= PH_HDR;
      kind           <= K_NONE;
      name_length    <= 8'd0;
      port_high_byte <= 8'd0;
      dropping       <= 1'b0;
    end else if (accept) begin
      kind           <= kind_next;
      name_length    <= name_length_next;
      port_high_byte <= port_high_byte_next;
      if (last) begin
        byte_index <= 16'd0;
        phase      <= PH_HDR;
        dropping   <= 1'b0;
      end else begin
        byte_index <= byte_index + 16'd1;
        phase      <= phase_next;
        dropping   <= dropping | drop;
      end
    end
  end

  // ---------------- address store and text ----------------
  s5r_addr_mem u_mem (
    .clk   (clk),
    .we    (accept && mem_we),
    .waddr (4'(byte_index - 16'd4)),
    .wdata (data_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The last address byte is written at the accepting edge; the sequencer
  // reads no earlier than the next cycle, so no forwarding path is needed.
  s5r_text_gen u_text (
    .clk   (clk),
    .rst   (rst),
    .start (accept && text_start),
    .is_v6 (kind == K_V6),
    .take  (take),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .txt   (txt)
  );

  // ---------------- output register and result queue ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ostate    <= S_IDLE;
      out_valid <= 1'b0;
      q_idx     <= 2'd0;
      q_cnt     <= 2'd0;
    end else begin
      case (ostate)
        S_IDLE: begin
          if (accept && n != 3'd0) begin
            out_valid <= 1'b1;
            out_byte  <= lb[0];
            out_last  <= l0_last;
            status    <= ls[0];
            for (int i = 0; i < 3; i++) begin
              q_byte[i] <= lb[i + 1];
              q_stat[i] <= ls[i + 1];
            end
            q_idx <= 2'd0;
            q_cnt <= 2'(n - 3'd1);
            if (n > 3'd1) begin
              ostate <= S_MULTI;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept && text_start) begin
            ostate <= S_TEXT;
          end
        end
        S_MULTI: begin
          // drain queued results one per cycle, hold while stalled
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= q_byte[q_idx];
            out_last  <= 1'b0;
            status    <= q_stat[q_idx];
            q_idx     <= q_idx + 2'd1;
            if (q_idx + 2'd1 == q_cnt) begin
              ostate <= S_IDLE;
            end
          end
        end
        S_TEXT: begin
          if (take) begin
            out_valid <= 1'b1;
            out_byte  <= txt.data;
            out_last  <= 1'b0;
            status    <= s5r_pkg::ST_DATA;
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (!txt.busy) begin
            ostate <= S_IDLE;
          end
        end
        default: begin
          ostate <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for socks5_udp_header_reframer: drives datagram
// bytes and APB register writes, predicts reframed items and compares them.
// Depends on s5r_pkg and the RTL in src.
module testbench;

  localparam int PH_HEADER  = 0;
  localparam int PH_NAMELEN = 1;
  localparam int PH_ADDRESS = 2;
  localparam int PH_NAME    = 3;
  localparam int PH_PORTHI  = 4;
  localparam int PH_PORTLO  = 5;
  localparam int PH_PAYLOAD = 6;

  localparam logic [1:0] KIND_V4   = 2'd1;
  localparam logic [1:0] KIND_V6   = 2'd2;
  localparam logic [1:0] KIND_NAME = 2'd3;

  localparam logic [7:0] ATYP_V4   = 8'd1;
  localparam logic [7:0] ATYP_NAME = 8'd3;
  localparam logic [7:0] ATYP_V6   = 8'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] code;
  } frame_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic [15:0] packet_length = 16'd1;
  logic [31:0] source_address = '0;
  logic [15:0] source_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [2:0]  status;

  socks5_udp_header_reframer dut (.*);

  initial forever #4 clk = ~clk;

  // Prediction state, mirrors the block
  logic        filt_en;
  logic [31:0] filt_addr;
  logic [15:0] filt_port;
  logic [15:0] pos;
  int          phase;
  logic [1:0]  kind;
  logic [7:0]  name_len;
  logic [7:0]  addr_bytes [16];
  logic [7:0]  port_hi;
  logic        dropped;
  logic [15:0] pay_len;

  frame_item_t expected_items[$];
  int          mismatches = 0;
  int          got_items = 0;

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void push(input logic [7:0] d, input logic l, input logic [2:0] c);
    expected_items.push_back('{data: d, last: l, code: c});
  endfunction

  function automatic void mark_drop(input logic [2:0] c);
    dropped = 1'b1;
    push(8'd0, 1'b0, c);
  endfunction

  function automatic int header_size();
    if (kind == KIND_V4) return 10;
    if (kind == KIND_V6) return 22;
    return 7 + name_len;
  endfunction

  function automatic logic [7:0] hexc(input logic [3:0] n);
    return (n < 10) ? 8'(8'h30 + n) : 8'(8'h41 + n - 10);
  endfunction

  function automatic void emit_dotted();
    int tot;
    int v;
    tot = 3;
    for (int i = 0; i < 4; i++) begin
      v = addr_bytes[i];
      tot += (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
    end
    push(tot[7:0], 1'b0, s5r_pkg::ST_DATA);
    for (int i = 0; i < 4; i++) begin
      v = addr_bytes[i];
      if (i != 0) push(8'h2E, 1'b0, s5r_pkg::ST_DATA);
      if (v >= 100) push(8'(8'h30 + v / 100), 1'b0, s5r_pkg::ST_DATA);
      if (v >= 10) push(8'(8'h30 + (v / 10) % 10), 1'b0, s5r_pkg::ST_DATA);
      push(8'(8'h30 + v % 10), 1'b0, s5r_pkg::ST_DATA);
    end
  endfunction

  function automatic void emit_hex_groups();
    push(8'd39, 1'b0, s5r_pkg::ST_DATA);
    for (int i = 0; i < 16; i++) begin
      if (i != 0 && i % 2 == 0) push(8'h3A, 1'b0, s5r_pkg::ST_DATA);
      push(hexc(addr_bytes[i][7:4]), 1'b0, s5r_pkg::ST_DATA);
      push(hexc(addr_bytes[i][3:0]), 1'b0, s5r_pkg::ST_DATA);
    end
  endfunction

  function automatic void reset_model();
    filt_en = 0; filt_addr = 0; filt_port = 0;
    pos = 0; phase = PH_HEADER; kind = 0; name_len = 0;
    foreach (addr_bytes[i]) addr_bytes[i] = 0;
    port_hi = 0; dropped = 0; pay_len = 0;
  endfunction

  // Work out the items caused by one accepted datagram byte
  function automatic void reframe_byte(input logic [7:0] b, input logic [15:0] plen,
                                       input logic [31:0] saddr, input logic [15:0] sport);
    logic     fin;
    int unsigned total;
    fin = (32'(pos) + 1 >= 32'(plen));
    total = plen;
    if (!dropped) begin
      case (phase)
        PH_HEADER: begin
          if (pos == 0) begin
            if (filt_en && (saddr != filt_addr || sport != filt_port))
              mark_drop(s5r_pkg::ST_SOURCE);
            else port_hi = b;
          end else if (pos == 1) begin
            if ((port_hi | b) != 0) mark_drop(s5r_pkg::ST_RESERVED);
          end else if (pos == 2) begin
            if (b != 0) mark_drop(s5r_pkg::ST_FRAGMENT);
          end else begin
            if (b == ATYP_V4 || b == ATYP_V6) begin
              kind = (b == ATYP_V4) ? KIND_V4 : KIND_V6;
              if (total <= header_size()) mark_drop(s5r_pkg::ST_SHORT);
              else phase = PH_ADDRESS;
            end else if (b == ATYP_NAME) begin
              kind = KIND_NAME;
              phase = PH_NAMELEN;
            end else mark_drop(s5r_pkg::ST_ADDRTYPE);
          end
        end
        PH_NAMELEN: begin
          name_len = b;
          if (total <= 7 + b) mark_drop(s5r_pkg::ST_SHORT);
          else begin
            push(b, 1'b0, s5r_pkg::ST_DATA);
            phase = (b != 0) ? PH_NAME : PH_PORTHI;
          end
        end
        PH_NAME: begin
          push(b, 1'b0, s5r_pkg::ST_DATA);
          if (pos >= 4 + name_len) phase = PH_PORTHI;
        end
        PH_ADDRESS: begin
          addr_bytes[(pos - 4) & 15] = b;
          if (fin) mark_drop(s5r_pkg::ST_SHORT);
          else if (kind == KIND_V4 && pos >= 7) begin
            emit_dotted(); phase = PH_PORTHI;
          end else if (kind == KIND_V6 && pos >= 19) begin
            emit_hex_groups(); phase = PH_PORTHI;
          end
        end
        PH_PORTHI: begin
          port_hi = b;
          phase = PH_PORTLO;
        end
        PH_PORTLO: begin
          if (fin || total <= header_size()) mark_drop(s5r_pkg::ST_SHORT);
          else begin
            pay_len = 16'(total - header_size());
            push(port_hi, 1'b0, s5r_pkg::ST_DATA);
            push(b, 1'b0, s5r_pkg::ST_DATA);
            push(pay_len[15:8], 1'b0, s5r_pkg::ST_DATA);
            push(pay_len[7:0], 1'b0, s5r_pkg::ST_DATA);
            phase = PH_PAYLOAD;
          end
        end
        default: push(b, fin, s5r_pkg::ST_DATA);
      endcase
      if (fin && !dropped && phase != PH_PAYLOAD) mark_drop(s5r_pkg::ST_SHORT);
    end
    if (fin) begin
      pos = 0; phase = PH_HEADER; dropped = 0;
    end else pos = pos + 16'd1;
  endfunction

  // Send one item; valid stays high until accepted, then the next item or
  // the idle gap follows at the next falling edge
  task automatic send_byte(input logic [7:0] b, input logic [15:0] plen,
                           input logic [31:0] saddr, input logic [15:0] sport);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 1) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b; packet_length <= plen; source_address <= saddr; source_port <= sport;
    do @(posedge clk); while (!in_ready);
    reframe_byte(b, plen, saddr, sport);
  endtask

  // Receiver: random stalls, compare each item with the oldest expectation
  initial begin
    frame_item_t want;
    int          hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) hold = 0;
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got_items++;
      if (expected_items.size() == 0) report($sformatf("unexpected item %h", out_byte));
      else begin
        want = expected_items.pop_front();
        if (out_byte !== want.data)
          report($sformatf("out_byte %h want %h", out_byte, want.data));
        if (out_last !== want.last)
          report($sformatf("out_last %b want %b", out_last, want.last));
        if (status !== want.code)
          report($sformatf("status %0d want %0d", status, want.code));
      end
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      s5r_pkg::REG_LIMIT_ENABLE:  filt_en = value[0];
      s5r_pkg::REG_LIMIT_ADDRESS: filt_addr = value;
      default:                    filt_port = value[15:0];
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drop valid after the last item, then wait for all expected items plus
  // the text sequencer's worst case
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Send one whole datagram from a byte list
  task automatic send_packet(input logic [7:0] bytes[$], input logic [31:0] saddr,
                             input logic [15:0] sport);
    foreach (bytes[i]) send_byte(bytes[i], 16'(bytes.size()), saddr, sport);
  endtask

  function automatic void build_packet(output logic [7:0] pkt[$], input logic [7:0] atyp,
                                       input int nlen, input int pay);
    pkt = {8'd0, 8'd0, 8'd0, atyp};
    if (atyp == ATYP_V4) repeat (4) pkt.push_back(8'($urandom));
    else if (atyp == ATYP_V6) repeat (16) pkt.push_back(8'($urandom));
    else begin
      pkt.push_back(8'(nlen));
      repeat (nlen) pkt.push_back(8'($urandom));
    end
    repeat (2) pkt.push_back(8'($urandom));
    repeat (pay) pkt.push_back(8'($urandom));
  endfunction

  task automatic test_directed();
    logic [7:0] pkt[$];
    // IPv4 with extreme octets
    pkt = {8'd0, 8'd0, 8'd0, ATYP_V4, 8'd0, 8'd255, 8'd9, 8'd100, 8'hFF, 8'h00, 8'hAB};
    send_packet(pkt, 32'd0, 16'd0);
    // IPv6 and an empty name
    build_packet(pkt, ATYP_V6, 0, 1);
    pkt[4] = 8'hFF; pkt[5] = 8'h0A;
    send_packet(pkt, 32'hFFFFFFFF, 16'hFFFF);
    build_packet(pkt, ATYP_NAME, 0, 2);
    send_packet(pkt, 32'd1, 16'd1);
    // reserved nonzero, fragment, bad address type
    send_packet({8'd1, 8'd0, 8'd0, ATYP_V4}, 0, 0);
    send_packet({8'd0, 8'd0, 8'd7, ATYP_V4}, 0, 0);
    send_packet({8'd0, 8'd0, 8'd0, 8'd255, 8'd0}, 0, 0);
    // too short at the address type and name length checks, and ends inside the header
    send_packet({8'd0, 8'd0, 8'd0, ATYP_V4, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6}, 0, 0);
    send_packet({8'd0, 8'd0, 8'd0, ATYP_NAME, 8'd2, 8'h61, 8'h62, 8'd0, 8'd0}, 0, 0);
    send_packet({8'd0, 8'd0}, 0, 0);
    send_byte(8'hFF, 16'd0, 0, 0);
    drain();
  endtask

  task automatic test_filter();
    logic [7:0] pkt[$];
    write_reg(s5r_pkg::REG_LIMIT_ADDRESS, 32'hC0A80001);
    write_reg(s5r_pkg::REG_LIMIT_PORT, 32'h0000FFFF);
    write_reg(s5r_pkg::REG_LIMIT_ENABLE, 32'd1);
    build_packet(pkt, ATYP_V4, 0, 2);
    send_packet(pkt, 32'hC0A80001, 16'hFFFF);
    send_packet(pkt, 32'hC0A80002, 16'hFFFF);
    send_packet(pkt, 32'hC0A80001, 16'h0000);
    drain();
    write_reg(s5r_pkg::REG_LIMIT_ADDRESS, 32'hFFFFFFFF);
    write_reg(s5r_pkg::REG_LIMIT_PORT, 32'd0);
    send_packet(pkt, 32'hFFFFFFFF, 16'd0);
    drain();
  endtask

  task automatic test_random(input int budget);
    logic [7:0]  pkt[$];
    logic [31:0] sa;
    logic [15:0] sp;
    int          sent;
    int          pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: build_packet(pkt, ATYP_V4, 0, $urandom_range(1, 6));
        3: build_packet(pkt, ATYP_V6, 0, $urandom_range(1, 4));
        4, 5: build_packet(pkt, ATYP_NAME, $urandom_range(0, 12), $urandom_range(1, 6));
        6: begin
          build_packet(pkt, ATYP_NAME, $urandom_range(0, 6), $urandom_range(1, 4));
          pkt[$urandom_range(0, 3)] = 8'($urandom);
        end
        7: begin
          build_packet(pkt, ATYP_V4, 0, 2);
          repeat ($urandom_range(1, 8)) void'(pkt.pop_back());
        end
        default: begin
          pkt = {};
          repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end
      endcase
      sa = ($urandom_range(0, 1) != 0) ? filt_addr : $urandom;
      sp = ($urandom_range(0, 1) != 0) ? filt_port : 16'($urandom);
      if (pick == 9 && $urandom_range(0, 1) != 0) begin
        // length field that disagrees with the real count
        foreach (pkt[i]) send_byte(pkt[i], 16'($urandom_range(0, 40)), sa, sp);
        while (pos != 0) send_byte(8'($urandom), 16'd1, sa, sp);
      end else send_packet(pkt, sa, sp);
      sent += pkt.size();
    end
    drain();
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_filter();
    write_reg(s5r_pkg::REG_LIMIT_ENABLE, 32'd0);
    test_random(200);
    write_reg(s5r_pkg::REG_LIMIT_ADDRESS, $urandom);
    write_reg(s5r_pkg::REG_LIMIT_PORT, $urandom);
    write_reg(s5r_pkg::REG_LIMIT_ENABLE, 32'd1);
    test_random(120);
    write_reg(s5r_pkg::REG_LIMIT_ENABLE, 32'd0);
    write_reg(s5r_pkg::REG_LIMIT_ADDRESS, 32'd0);
    write_reg(s5r_pkg::REG_LIMIT_PORT, 32'd0);
    test_random(160);
    if (mismatches == 0 && expected_items.size() == 0)
      $display("socks5_udp_header_reframer regression: pass");
    else
      $display("socks5_udp_header_reframer regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("socks5_udp_header_reframer regression: fail");
    $finish;
  end

endmodule

### filelist.f
src/s5r_pkg.sv
src/s5r_addr_mem.sv
src/s5r_text_gen.sv
src/socks5_udp_header_reframer.sv
tb/sv/testbench.sv
